FILE: rtl/lla_pkg.sv
// Shared types and constants for the life-like automaton step unit.
// Holds field widths, register and op codes, FSM states and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package lla_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_MAX_HEIGHT = 64;

  // Neighbor counts run 0..8, so a rule mask has nine bits
  localparam int unsigned MASK_W      = 9;
  localparam int unsigned SIZE_W      = 7;
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [MASK_W-1:0] RST_SURVIVE = 9'd12;
  localparam logic [MASK_W-1:0] RST_BIRTH   = 9'd8;
  localparam logic [SIZE_W-1:0] RST_SIZE    = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURVIVE = 3'd0,
    REG_BIRTH   = 3'd1,
    REG_WRAP    = 3'd2,
    REG_WIDTH   = 3'd3,
    REG_HEIGHT  = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_DO,
    ST_GEN_RD,
    ST_GEN_WAIT,
    ST_GEN_FIN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [MASK_W-1:0] survive;
    logic [MASK_W-1:0] birth;
    logic              wrap;
  } cfg_t;

  typedef struct packed {
    logic latch;      // capture the accepted item, clear the sweep counter
    logic cell_rd;    // read the addressed row
    logic cell_do;    // modify or sample the addressed row
    logic gen_rd;     // issue the next sweep read
    logic gen_fin;    // compute and write the last row of the sweep
    logic resp_load;  // load the result register
  } cmd_t;

  typedef struct packed {
    op_e  in_op;
    logic in_err;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/life_like_automaton_step_unit.sv
// Top level of the life-like automaton step unit: config registers,
// controller FSM and datapath. Depends on lla_pkg, lla_cfg, lla_ctrl, lla_dpath.
//
//   Channel   Direction  Handshake                      Payload
//   cfg       in         cfg_we_i                       cfg_index_i, cfg_wdata_i
//   s_axis    in         s_axis_tvalid / s_axis_tready  op, col, row, write_value
//   m_axis    out        m_axis_tvalid / m_axis_tready  read_value, status
//
// One item at a time. Cell write or read: a read-modify-write through the
// row memory's separate read and write ports. Advance: one memory row read
// per cycle through the sweep. Out-of-range or unused op goes straight to
// the result. Reset clears the board at once through per-row valid bits.
// A held result stalls only the next item's delivery; the next item is
// still accepted.
`default_nettype none

module life_like_automaton_step_unit #(
  parameter int unsigned MAX_WIDTH  = lla_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = lla_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [lla_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [1:0] op, [7:2] col, [13:8] row, [14] write_value, [15] zero
  input  wire logic [lla_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] read_value, [1] status, [7:2] zero
  output logic [lla_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned UW_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned UH_W = $clog2(MAX_HEIGHT + 1);

  lla_pkg::cfg_t   cfg;
  lla_pkg::cmd_t   cmd;
  lla_pkg::sts_t   sts;
  logic [UW_W-1:0] used_w;
  logic [UH_W-1:0] used_h;

  lla_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .used_w_o    (used_w),
    .used_h_o    (used_h)
  );

  lla_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  lla_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg),
    .used_w_i      (used_w),
    .used_h_i      (used_h),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/lla_cfg.sv
// Configuration registers of the automaton: rule masks, edge mode and
// board size, with the size clamped to the storage limits.
// Depends on lla_pkg.
`default_nettype none

module lla_cfg #(
  parameter int unsigned MAX_WIDTH  = lla_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = lla_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned UW_W = $clog2(MAX_WIDTH + 1),
  localparam int unsigned UH_W = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [lla_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output lla_pkg::cfg_t                        cfg_o,
  output logic [UW_W-1:0]                      used_w_o,
  output logic [UH_W-1:0]                      used_h_o
);

  localparam int unsigned CMPW_W = UW_W + lla_pkg::SIZE_W;
  localparam int unsigned CMPH_W = UH_W + lla_pkg::SIZE_W;

  logic [lla_pkg::MASK_W-1:0] survive_q, birth_q;
  logic                       wrap_q;
  logic [lla_pkg::SIZE_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      survive_q <= lla_pkg::RST_SURVIVE;
      birth_q   <= lla_pkg::RST_BIRTH;
      wrap_q    <= 1'b0;
      width_q   <= lla_pkg::RST_SIZE;
      height_q  <= lla_pkg::RST_SIZE;
    end else if (cfg_we_i) begin
      case (lla_pkg::reg_e'(cfg_index_i))
        lla_pkg::REG_SURVIVE: survive_q <= cfg_wdata_i[lla_pkg::MASK_W-1:0];
        lla_pkg::REG_BIRTH:   birth_q   <= cfg_wdata_i[lla_pkg::MASK_W-1:0];
        lla_pkg::REG_WRAP:    wrap_q    <= cfg_wdata_i[0];
        lla_pkg::REG_WIDTH:   width_q   <= cfg_wdata_i[lla_pkg::SIZE_W-1:0];
        lla_pkg::REG_HEIGHT:  height_q  <= cfg_wdata_i[lla_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.survive = survive_q;
  assign cfg_o.birth   = birth_q;
  assign cfg_o.wrap    = wrap_q;

  // Zero counts as one, anything above the storage limit as the limit
  always_comb begin
    if (width_q == '0) begin
      used_w_o = UW_W'(1);
    end else if (CMPW_W'(width_q) > CMPW_W'(MAX_WIDTH)) begin
      used_w_o = UW_W'(MAX_WIDTH);
    end else begin
      used_w_o = UW_W'(width_q);
    end
  end

  always_comb begin
    if (height_q == '0) begin
      used_h_o = UH_W'(1);
    end else if (CMPH_W'(height_q) > CMPH_W'(MAX_HEIGHT)) begin
      used_h_o = UH_W'(MAX_HEIGHT);
    end else begin
      used_h_o = UH_W'(height_q);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lla_ctrl.sv
// Sequencing FSM of the automaton: accepts items, steps cell accesses and
// the generation sweep, and hands results to the output register.
// Depends on lla_pkg.
`default_nettype none

module lla_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_axis_tvalid,
  output logic          s_axis_tready,
  input  lla_pkg::sts_t sts_i,
  output lla_pkg::cmd_t cmd_o
);

  lla_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lla_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lla_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (sts_i.in_op)
            lla_pkg::OP_ADVANCE: state_d = lla_pkg::ST_GEN_RD;
            lla_pkg::OP_WRITE,
            lla_pkg::OP_READ: begin
              state_d = sts_i.in_err ? lla_pkg::ST_RESP : lla_pkg::ST_CELL_RD;
            end
            default: state_d = lla_pkg::ST_RESP;
          endcase
        end
      end
      lla_pkg::ST_CELL_RD:  state_d = lla_pkg::ST_CELL_DO;
      lla_pkg::ST_CELL_DO:  state_d = lla_pkg::ST_RESP;
      lla_pkg::ST_GEN_RD: begin
        if (sts_i.rd_last) begin
          state_d = lla_pkg::ST_GEN_WAIT;
        end
      end
      lla_pkg::ST_GEN_WAIT: state_d = lla_pkg::ST_GEN_FIN;
      lla_pkg::ST_GEN_FIN:  state_d = lla_pkg::ST_RESP;
      lla_pkg::ST_RESP: begin
        if (sts_i.out_free) begin
          state_d = lla_pkg::ST_IDLE;
        end
      end
      default: state_d = lla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    case (state_q)
      lla_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.latch   = s_axis_tvalid;
      end
      lla_pkg::ST_CELL_RD: cmd_o.cell_rd = 1'b1;
      lla_pkg::ST_CELL_DO: cmd_o.cell_do = 1'b1;
      lla_pkg::ST_GEN_RD:  cmd_o.gen_rd  = 1'b1;
      lla_pkg::ST_GEN_FIN: cmd_o.gen_fin = 1'b1;
      lla_pkg::ST_RESP:    cmd_o.resp_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lla_dpath.sv
// Datapath of the automaton: row memory with per-row valid bits, item
// capture, three-row sweep window, next-generation row logic and the
// result register. Depends on lla_pkg.
`default_nettype none

module lla_dpath #(
  parameter int unsigned MAX_WIDTH  = lla_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = lla_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned UW_W = $clog2(MAX_WIDTH + 1),
  localparam int unsigned UH_W = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  lla_pkg::cmd_t                         cmd_i,
  output lla_pkg::sts_t                         sts_o,
  input  lla_pkg::cfg_t                         cfg_i,
  input  wire logic [UW_W-1:0]                  used_w_i,
  input  wire logic [UH_W-1:0]                  used_h_i,
  input  wire logic [lla_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [lla_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  localparam int unsigned AW    = $clog2(MAX_HEIGHT);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned CMPW  = UW_W + lla_pkg::COORD_W;
  localparam int unsigned CMPH  = UH_W + lla_pkg::COORD_W;

  // Incoming item fields
  lla_pkg::op_e                in_op;
  logic [lla_pkg::COORD_W-1:0] in_col, in_row;
  logic                        in_wv, in_bad;

  assign in_op  = lla_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_col = s_axis_tdata[7:2];
  assign in_row = s_axis_tdata[13:8];
  assign in_wv  = s_axis_tdata[14];
  assign in_bad = (CMPW'(in_col) >= CMPW'(used_w_i)) || (CMPH'(in_row) >= CMPH'(used_h_i));

  assign sts_o.in_op  = in_op;
  assign sts_o.in_err = in_bad && ((in_op == lla_pkg::OP_WRITE) || (in_op == lla_pkg::OP_READ));

  lla_pkg::op_e    op_q;
  logic [CW-1:0]   col_q;
  logic [AW-1:0]   row_q;
  logic            wv_q, err_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= in_op;
      col_q <= CW'(in_col);
      row_q <= AW'(in_row);
      wv_q  <= in_wv;
      err_q <= sts_o.in_err;
    end
  end

  // Row memory; a row never written since reset reads as all dead
  logic [MAX_WIDTH-1:0]  mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] vld_q;
  logic                  rd_en, we, rd_vld_q;
  logic [AW-1:0]         rd_addr, wr_addr, last_row;
  logic [MAX_WIDTH-1:0]  wr_data, rd_mem_q, rd_row;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_mem_q <= mem[rd_addr];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (we) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_row = rd_vld_q ? rd_mem_q : '0;

  // Sweep: read k = 0 fetches the last row (upper wrap neighbor of row 0),
  // read k >= 1 fetches row k-1
  logic [UH_W-1:0] rd_cnt_q, dk_q;
  logic            dv_q;

  assign last_row      = AW'(used_h_i - UH_W'(1));
  assign sts_o.rd_last = (rd_cnt_q == used_h_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      dv_q     <= 1'b0;
      dk_q     <= '0;
    end else begin
      if (cmd_i.latch) begin
        rd_cnt_q <= '0;
      end else if (cmd_i.gen_rd) begin
        rd_cnt_q <= rd_cnt_q + UH_W'(1);
      end
      dv_q <= cmd_i.gen_rd;
      dk_q <= rd_cnt_q;
    end
  end

  always_comb begin
    rd_en = cmd_i.cell_rd || cmd_i.gen_rd;
    if (cmd_i.cell_rd) begin
      rd_addr = row_q;
    end else if (rd_cnt_q == '0) begin
      rd_addr = last_row;
    end else begin
      rd_addr = AW'(rd_cnt_q - UH_W'(1));
    end
  end

  // Window: rows above, at and below the row being computed
  logic [MAX_WIDTH-1:0] prev_q, cur_q, first_q, dn_row, new_row;
  logic                 dk_comp;

  assign dk_comp = dv_q && (dk_q > UH_W'(1));
  assign dn_row  = cmd_i.gen_fin ? (cfg_i.wrap ? first_q : '0) : rd_row;

  always_ff @(posedge clk_i) begin
    if (dv_q) begin
      if (dk_q == '0) begin
        prev_q <= cfg_i.wrap ? rd_row : '0;
      end else if (dk_q == UH_W'(1)) begin
        cur_q   <= rd_row;
        first_q <= rd_row;
      end else begin
        prev_q <= cur_q;
        cur_q  <= rd_row;
      end
    end
  end

  // Next-generation row logic
  logic [CW-1:0] wm1;
  assign wm1 = CW'(used_w_i - UW_W'(1));

  function automatic logic [MAX_WIDTH-1:0] from_left(input logic [MAX_WIDTH-1:0] r,
                                                     input logic wrap,
                                                     input logic [CW-1:0] last);
    logic [MAX_WIDTH-1:0] v;
    v    = {r[MAX_WIDTH-2:0], 1'b0};
    v[0] = wrap & r[last];
    return v;
  endfunction

  function automatic logic [MAX_WIDTH-1:0] from_right(input logic [MAX_WIDTH-1:0] r,
                                                      input logic wrap,
                                                      input logic [CW-1:0] last);
    logic [MAX_WIDTH-1:0] v;
    v       = {1'b0, r[MAX_WIDTH-1:1]};
    v[last] = wrap & r[0];
    return v;
  endfunction

  logic [MAX_WIDTH-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
  logic [lla_pkg::CNT_W-1:0] cnt [MAX_WIDTH];

  assign up_l  = from_left(prev_q, cfg_i.wrap, wm1);
  assign up_r  = from_right(prev_q, cfg_i.wrap, wm1);
  assign mid_l = from_left(cur_q, cfg_i.wrap, wm1);
  assign mid_r = from_right(cur_q, cfg_i.wrap, wm1);
  assign dn_l  = from_left(dn_row, cfg_i.wrap, wm1);
  assign dn_r  = from_right(dn_row, cfg_i.wrap, wm1);

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      cnt[c] = lla_pkg::CNT_W'(up_l[c]) + lla_pkg::CNT_W'(prev_q[c])
             + lla_pkg::CNT_W'(up_r[c]) + lla_pkg::CNT_W'(mid_l[c])
             + lla_pkg::CNT_W'(mid_r[c]) + lla_pkg::CNT_W'(dn_l[c])
             + lla_pkg::CNT_W'(dn_row[c]) + lla_pkg::CNT_W'(dn_r[c]);
      // Columns outside the board keep their old value
      if (UW_W'(c) < used_w_i) begin
        new_row[c] = cur_q[c] ? cfg_i.survive[cnt[c]] : cfg_i.birth[cnt[c]];
      end else begin
        new_row[c] = cur_q[c];
      end
    end
  end

  // Write port: cell write-back or computed sweep row
  always_comb begin
    we      = dk_comp || cmd_i.gen_fin || (cmd_i.cell_do && (op_q == lla_pkg::OP_WRITE));
    wr_data = new_row;
    if (cmd_i.cell_do) begin
      wr_addr        = row_q;
      wr_data        = rd_row;
      wr_data[col_q] = wv_q;
    end else if (cmd_i.gen_fin) begin
      wr_addr = last_row;
    end else begin
      wr_addr = AW'(dk_q - UH_W'(2));
    end
  end

  // Sampled cell and result register
  logic rbit_q, out_vld_q, rv_q, st_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_do) begin
      rbit_q <= rd_row[col_q];
    end
    if (cmd_i.resp_load) begin
      rv_q <= (op_q == lla_pkg::OP_READ) && !err_q && rbit_q;
      st_q <= err_q && ((op_q == lla_pkg::OP_WRITE) || (op_q == lla_pkg::OP_READ));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid  = out_vld_q;
  assign m_axis_tdata   = {{(lla_pkg::OUT_TDATA_W - 2){1'b0}}, st_q, rv_q};

endmodule

`default_nettype wire
